// File: src/rtc_pkg.sv
// Shared types, constants and calendar helper functions for the RTC block.
// No dependencies; every other file in src imports this package.
package rtc_pkg;

  localparam int ACTION_W = 2;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 12;

  localparam logic [HOUR_W-1:0]  HOUR_MAX  = HOUR_W'(23);
  localparam logic [MIN_W-1:0]   MIN_MAX   = MIN_W'(59);
  localparam logic [SEC_W-1:0]   SEC_MAX   = SEC_W'(59);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);

  // floor(y/25) for y < 4096 as (y * 5243) >> 17
  localparam logic [12:0] DIV25_RECIP = 13'd5243;
  localparam int          DIV25_SHIFT = 17;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 2'd0,
    ACT_LOAD_TIME = 2'd1,
    ACT_LOAD_DATE = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  // Date update request from the time-of-day logic to the calendar unit.
  typedef struct packed {
    logic                 advance;
    logic                 load;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } cal_ctrl_t;

  // True when y is a multiple of 25.
  function automatic logic is_mult25(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+12:0] prod;
    logic [7:0]         q;
    logic [YEAR_W-1:0]  back;
    prod = {13'd0, y} * {{YEAR_W{1'b0}}, DIV25_RECIP};
    q    = prod[DIV25_SHIFT+7:DIV25_SHIFT];
    back = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
    return back == y;
  endfunction

  // Gregorian leap: multiple of 4, and either not a century or a multiple of 400.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (!is_mult25(y) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(31);
    if (m == MONTH_FEB) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = DAY_W'(30);
    end
    return len;
  endfunction

endpackage

// File: src/rtc_if.sv
// Valid/ready channel interfaces for RTC commands and RTC results.
// Depends on rtc_pkg for field widths.
interface rtc_in_if;
  import rtc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [HOUR_W-1:0]   load_hours;
  logic [MIN_W-1:0]    load_minutes;
  logic [SEC_W-1:0]    load_seconds;
  logic [DAY_W-1:0]    load_day;
  logic [MONTH_W-1:0]  load_month;
  logic [YEAR_W-1:0]   load_year;

  modport source (output valid, action, load_hours, load_minutes, load_seconds,
                  load_day, load_month, load_year, input ready);
  modport sink   (input valid, action, load_hours, load_minutes, load_seconds,
                  load_day, load_month, load_year, output ready);
endinterface

interface rtc_out_if;
  import rtc_pkg::*;
  logic               valid;
  logic               ready;
  logic [HOUR_W-1:0]  hours;
  logic [MIN_W-1:0]   minutes;
  logic [SEC_W-1:0]   seconds;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic               hour_boundary;

  modport source (output valid, hours, minutes, seconds, day, month, year,
                  hour_boundary, input ready);
  modport sink   (input valid, hours, minutes, seconds, day, month, year,
                  hour_boundary, output ready);
endinterface

// File: src/rtc_time_of_day_calendar.sv
// Real-time clock with Gregorian calendar: top level.
// The result of an input transfer is in the output register from the next cycle on.
// Throughput: 1 item per cycle; an item is taken whenever the output register is
// empty or being drained in the same cycle. Time and date update in one pass.
// Reset (synchronous, rst_n low): 00:00:00 on day 1, month 1, year 0; no result held.
// Depends on rtc_pkg, rtc_if (rtc_in_if, rtc_out_if) and rtc_cal_unit.
module rtc_time_of_day_calendar (
  input  logic      clk,
  input  logic      rst_n,
  rtc_in_if.sink    in_if,
  rtc_out_if.source out_if
);
  import rtc_pkg::*;

  // Time of day is held split into h/m/s, so no divider is needed for output.
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  min_r,  min_nxt;
  logic [SEC_W-1:0]  sec_r,  sec_nxt;

  // Output register (one-deep, decouples the two handshakes).
  logic               out_valid_r, out_valid_nxt;
  logic [HOUR_W-1:0]  out_hour_r;
  logic [MIN_W-1:0]   out_min_r;
  logic [SEC_W-1:0]   out_sec_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic               out_hb_r;

  logic               in_ready;
  logic               accept;
  action_t            act;
  logic               day_wrap;
  cal_ctrl_t          cal_ctrl;
  logic [DAY_W-1:0]   day_nxt;
  logic [MONTH_W-1:0] month_nxt;
  logic [YEAR_W-1:0]  year_nxt;

  assign in_ready    = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;
  assign act         = action_t'(in_if.action);

  // Next time of day: tick carries s -> m -> h -> day; a time load clamps fields.
  always_comb begin
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    day_wrap = 1'b0;
    if (accept) begin
      case (act)
        ACT_TICK: begin
          if (sec_r < SEC_MAX) begin
            sec_nxt = sec_r + SEC_W'(1);
          end else begin
            sec_nxt = '0;
            if (min_r < MIN_MAX) begin
              min_nxt = min_r + MIN_W'(1);
            end else begin
              min_nxt = '0;
              if (hour_r < HOUR_MAX) begin
                hour_nxt = hour_r + HOUR_W'(1);
              end else begin
                hour_nxt = '0;
                day_wrap = 1'b1;     // 86400 reached
              end
            end
          end
        end
        ACT_LOAD_TIME: begin
          hour_nxt = (in_if.load_hours   > HOUR_MAX) ? HOUR_MAX : in_if.load_hours;
          min_nxt  = (in_if.load_minutes > MIN_MAX)  ? MIN_MAX  : in_if.load_minutes;
          sec_nxt  = (in_if.load_seconds > SEC_MAX)  ? SEC_MAX  : in_if.load_seconds;
        end
        ACT_LOAD_DATE: ;
        ACT_NONE:      ;
        default:       ;
      endcase
    end
  end

  always_comb begin
    cal_ctrl.advance = day_wrap;
    cal_ctrl.load    = accept && (act == ACT_LOAD_DATE);
    cal_ctrl.day     = in_if.load_day;
    cal_ctrl.month   = in_if.load_month;
    cal_ctrl.year    = in_if.load_year;
  end

  rtc_cal_unit u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (cal_ctrl),
    .day_nxt   (day_nxt),
    .month_nxt (month_nxt),
    .year_nxt  (year_nxt)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded on every input transfer with the post-update state.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hour_r  <= hour_nxt;
      out_min_r   <= min_nxt;
      out_sec_r   <= sec_nxt;
      out_day_r   <= day_nxt;
      out_month_r <= month_nxt;
      out_year_r  <= year_nxt;
      out_hb_r    <= (min_nxt == '0) && (sec_nxt == '0);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.hours         = out_hour_r;
  assign out_if.minutes       = out_min_r;
  assign out_if.seconds       = out_sec_r;
  assign out_if.day           = out_day_r;
  assign out_if.month         = out_month_r;
  assign out_if.year          = out_year_r;
  assign out_if.hour_boundary = out_hb_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("input transfer without a result");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= HOUR_MAX) && (min_r <= MIN_MAX) && (sec_r <= SEC_MAX))
    else $error("time of day out of range");

  a_hb_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hb_r == ((out_min_r == '0) && (out_sec_r == '0))))
    else $error("hour boundary flag disagrees with time");

  a_no_state_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(hour_r) && $stable(min_r) && $stable(sec_r))
    else $error("time changed without an input transfer");

endmodule

// File: src/rtc_cal_unit.sv
// Calendar state: day, month, year and a registered leap flag.
// Depends on rtc_pkg (cal_ctrl_t, month_length, is_leap).
module rtc_cal_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rtc_pkg::cal_ctrl_t          ctrl,
  output logic [rtc_pkg::DAY_W-1:0]   day_nxt,
  output logic [rtc_pkg::MONTH_W-1:0] month_nxt,
  output logic [rtc_pkg::YEAR_W-1:0]  year_nxt
);
  import rtc_pkg::*;

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic               leap_r;
  logic               leap_nxt;
  logic [DAY_W-1:0]   ld_day;
  logic [MONTH_W-1:0] ld_month;

  always_comb begin
    ld_day   = (ctrl.day == '0) ? DAY_FIRST : ctrl.day;
    ld_month = ctrl.month;
    if (ctrl.month == '0) begin
      ld_month = MONTH_JAN;
    end else if (ctrl.month > MONTH_DEC) begin
      ld_month = MONTH_DEC;
    end
  end

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (ctrl.load) begin
      day_nxt   = ld_day;
      month_nxt = ld_month;
      year_nxt  = ctrl.year;
    end else if (ctrl.advance) begin
      if (day_r < month_length(month_r, leap_r)) begin
        day_nxt = day_r + DAY_W'(1);
      end else if (month_r >= MONTH_DEC) begin
        day_nxt   = DAY_FIRST;
        month_nxt = MONTH_JAN;
        year_nxt  = year_r + YEAR_W'(1);   // wraps at 4096
      end else begin
        day_nxt   = DAY_FIRST;
        month_nxt = month_r + MONTH_W'(1);
      end
    end
    leap_nxt = is_leap(year_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_FIRST;
      month_r <= MONTH_JAN;
      year_r  <= '0;
      leap_r  <= 1'b1;    // year 0 is a multiple of 400
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      leap_r  <= leap_nxt;
    end
  end

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC))
    else $error("month out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    day_r != '0)
    else $error("day of month is zero");

  a_leap_tracks_year: assert property (@(posedge clk) disable iff (!rst_n)
    leap_r == is_leap(year_r))
    else $error("leap flag out of step with year");

  a_advance_rollover: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.advance && !ctrl.load && day_r >= month_length(month_r, leap_r)) |=>
      (day_r == DAY_FIRST))
    else $error("month end did not roll to day one");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for rtc_time_of_day_calendar: ticks, time loads and date loads.
// A predictor class mirrors the clock and calendar and checks every reading in order.
// Depends on rtc_pkg and the channel interfaces rtc_in_if / rtc_out_if.
module testbench;
  import rtc_pkg::*;

  // Longest legal quiet stretch is the receiver hold-off (HOLD_CYCLES); this is
  // several times that.
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 225;
  localparam int SECS_PER_DAY = 86400;
  localparam int SECS_PER_HR  = 3600;
  localparam int SECS_PER_MIN = 60;

  // One command as offered on the input channel.
  typedef struct {
    action_t             action;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } rtc_cmd_t;

  // One time/date reading as returned on the output channel.
  typedef struct {
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic                hour_boundary;
  } rtc_reading_t;

  // Clock/calendar mirror plus the queue of readings still owed by the block.
  class rtc_expected_clock;
    logic [16:0]        sod;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    rtc_reading_t       readings_due[$];
    int                 errors;

    function new();
      sod    = '0;
      day    = DAY_W'(1);
      month  = MONTH_W'(1);
      year   = '0;
      errors = 0;
    endfunction

    static function bit leap_year(logic [YEAR_W-1:0] y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int month_days(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
      case (m)
        4'd2: begin
          return leap_year(y) ? 29 : 28;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    // Midnight rollover; a day past the month length still moves to day 1.
    function void next_day();
      if (day < month_days(month, year)) begin
        day = day + DAY_W'(1);
      end else if (month >= MONTH_DEC) begin
        day   = DAY_W'(1);
        month = MONTH_JAN;
        year  = year + YEAR_W'(1);
      end else begin
        day   = DAY_W'(1);
        month = month + MONTH_W'(1);
      end
    endfunction

    // Apply one accepted command and queue the reading it must produce.
    function void note_command(rtc_cmd_t c);
      rtc_reading_t r;
      logic [HOUR_W-1:0]  h;
      logic [MIN_W-1:0]   m;
      logic [SEC_W-1:0]   s;
      logic [DAY_W-1:0]   d;
      logic [MONTH_W-1:0] mo;
      case (c.action)
        ACT_TICK: begin
          sod = sod + 17'd1;
          if (sod >= SECS_PER_DAY) begin
            sod = '0;
            next_day();
          end
        end
        ACT_LOAD_TIME: begin
          h   = (c.hours > HOUR_MAX) ? HOUR_MAX : c.hours;
          m   = (c.minutes > MIN_MAX) ? MIN_MAX : c.minutes;
          s   = (c.seconds > SEC_MAX) ? SEC_MAX : c.seconds;
          sod = 17'(h * SECS_PER_HR + m * SECS_PER_MIN + s);
        end
        ACT_LOAD_DATE: begin
          d  = (c.day == '0) ? DAY_W'(1) : c.day;
          mo = (c.month == '0) ? MONTH_JAN : c.month;
          if (mo > MONTH_DEC) begin
            mo = MONTH_DEC;
          end
          day   = d;
          month = mo;
          year  = c.year;
        end
        default: begin
        end
      endcase
      r.hours         = HOUR_W'(sod / SECS_PER_HR);
      r.minutes       = MIN_W'((sod % SECS_PER_HR) / SECS_PER_MIN);
      r.seconds       = SEC_W'(sod % SECS_PER_MIN);
      r.day           = day;
      r.month         = month;
      r.year          = year;
      r.hour_boundary = (sod % SECS_PER_HR) == 0;
      readings_due.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(rtc_reading_t got);
      rtc_reading_t want;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading, expected none, actual %0d:%0d:%0d %0d/%0d/%0d",
                 $time, got.hours, got.minutes, got.seconds, got.day, got.month, got.year);
        errors++;
        return;
      end
      want = readings_due.pop_front();
      compare_field("hours",         want.hours,         got.hours);
      compare_field("minutes",       want.minutes,       got.minutes);
      compare_field("seconds",       want.seconds,       got.seconds);
      compare_field("day",           want.day,           got.day);
      compare_field("month",         want.month,         got.month);
      compare_field("year",          want.year,          got.year);
      compare_field("hour_boundary", want.hour_boundary, got.hour_boundary);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rtc_in_if  in_ch();
  rtc_out_if out_ch();

  rtc_time_of_day_calendar dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  rtc_expected_clock clock_ref = new();

  // Traffic shaping knobs, written by the main sequence, read by driver/receiver.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Command builders. Fields the action ignores carry random values so every
  // payload bit still toggles.
  // ---------------------------------------------------------------------------
  function automatic rtc_cmd_t mk_noise();
    rtc_cmd_t c;
    c.action  = action_t'($urandom_range(3));
    c.hours   = HOUR_W'($urandom);
    c.minutes = MIN_W'($urandom);
    c.seconds = SEC_W'($urandom);
    c.day     = DAY_W'($urandom);
    c.month   = MONTH_W'($urandom);
    c.year    = YEAR_W'($urandom);
    return c;
  endfunction

  function automatic rtc_cmd_t mk_tick();
    rtc_cmd_t c;
    c        = mk_noise();
    c.action = ACT_TICK;
    return c;
  endfunction

  function automatic rtc_cmd_t mk_idle_cmd();
    rtc_cmd_t c;
    c        = mk_noise();
    c.action = ACT_NONE;
    return c;
  endfunction

  function automatic rtc_cmd_t mk_time(int h, int m, int s);
    rtc_cmd_t c;
    c         = mk_noise();
    c.action  = ACT_LOAD_TIME;
    c.hours   = HOUR_W'(h);
    c.minutes = MIN_W'(m);
    c.seconds = SEC_W'(s);
    return c;
  endfunction

  function automatic rtc_cmd_t mk_date(int d, int mo, int y);
    rtc_cmd_t c;
    c        = mk_noise();
    c.action = ACT_LOAD_DATE;
    c.day    = DAY_W'(d);
    c.month  = MONTH_W'(mo);
    c.year   = YEAR_W'(y);
    return c;
  endfunction

  // Date, mostly near a month end, with years that stress the leap rule.
  function automatic rtc_cmd_t pick_date();
    int mo;
    int y;
    int len;
    int d;
    mo = $urandom_range(1, 12);
    case ($urandom_range(4))
      0: y = 400 * $urandom_range(10);
      1: y = 100 * $urandom_range(40);
      2: y = 4 * $urandom_range(1023);
      3: y = 4095;
      default: y = $urandom_range(4095);
    endcase
    len = rtc_expected_clock::month_days(MONTH_W'(mo), YEAR_W'(y));
    case ($urandom_range(3))
      0: d = len;
      1: d = len - 1;
      2: d = 31;
      default: d = $urandom_range(1, 31);
    endcase
    return mk_date(d, mo, y);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: optional idle cycles, then hold valid until the transfer.
  // valid stays high into the next call so back-to-back items need no gap.
  // ---------------------------------------------------------------------------
  task automatic push(input rtc_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= c.action;
    in_ch.load_hours   <= c.hours;
    in_ch.load_minutes <= c.minutes;
    in_ch.load_seconds <= c.seconds;
    in_ch.load_day     <= c.day;
    in_ch.load_month   <= c.month;
    in_ch.load_year    <= c.year;
    do @(posedge clk); while (!in_ch.ready);
    clock_ref.note_command(c);
    items_sent++;
  endtask

  // Stop offering and wait for every owed reading.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (clock_ref.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Set 23:59:59 and tick across midnight.
  task automatic cross_midnight();
    push(mk_time(23, 59, 59));
    push(mk_tick());
  endtask

  task automatic directed_items();
    push(mk_idle_cmd());              // unused action reports reset state
    push(mk_tick());
    cross_midnight();
    push(mk_time(31, 63, 63));        // all fields above range, clamp to 23:59:59
    push(mk_date(31, 12, 4095));
    push(mk_tick());                  // year wraps to zero
    push(mk_date(0, 0, 4095));        // zero day and month load as one
    push(mk_date(28, 2, 2000));       // multiple of 400: leap
    cross_midnight();
    cross_midnight();
    push(mk_date(28, 2, 1900));       // century: not leap
    cross_midnight();
    push(mk_date(31, 4, 2024));       // day past month length
    cross_midnight();
    push(mk_date(31, 15, 2023));      // month above 12 loads as December
    cross_midnight();
    push(mk_time(0, 59, 59));
    push(mk_tick());                  // lands on an hour boundary
    push(mk_date(29, 2, 0));          // year zero is leap
    cross_midnight();
  endtask

  // Mostly rollover sequences with random content, some hour crossings, some noise.
  task automatic random_burst();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      push(pick_date());
      push(mk_time(23, 59, $urandom_range(50, 59)));
      repeat ($urandom_range(1, 14)) push(mk_tick());
    end else if (sel < 80) begin
      if ($urandom_range(1)) begin
        push(mk_time($urandom_range(23), 59, $urandom_range(50, 59)));
      end else begin
        push(mk_time($urandom_range(23), $urandom_range(59), $urandom_range(59)));
      end
      repeat ($urandom_range(1, 20)) push(mk_tick());
    end else begin
      repeat ($urandom_range(1, 4)) push(mk_noise());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each transfer, then pick ready for the next edge.
  // A long hold-off, once requested, is counted down here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rtc_reading_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.hours         = out_ch.hours;
        got.minutes       = out_ch.minutes;
        got.seconds       = out_ch.seconds;
        got.day           = out_ch.day;
        got.month         = out_ch.month;
        got.year          = out_ch.year;
        got.hour_boundary = out_ch.hour_boundary;
        clock_ref.check_reading(got);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run with FAILURE once the quiet count, kept while neither channel moves, reaches QUIET_LIMIT.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed items, then four traffic phases.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int idle_by_phase[4];
    int stall_by_phase[4];
    int phase_end;
    idle_by_phase  = '{0, 49, 0, 37};
    stall_by_phase = '{0, 0, 49, 37};
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.load_hours   <= '0;
    in_ch.load_minutes <= '0;
    in_ch.load_seconds <= '0;
    in_ch.load_day     <= '0;
    in_ch.load_month   <= '0;
    in_ch.load_year    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      phase_end      = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        random_burst();
      end
      if (ph == 0) begin
        // Back-pressure: output held off while the driver keeps offering,
        // then a full drain with the input quiet.
        hold_left = HOLD_CYCLES;
        repeat (24) push(($urandom_range(3) == 0) ? mk_noise() : mk_tick());
        drain();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (clock_ref.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rtc_pkg.sv
src/rtc_if.sv
src/rtc_cal_unit.sv
src/rtc_time_of_day_calendar.sv
tb/sv/testbench.sv
